// ===== sv/chunk_pool_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Chunk pool allocator assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CHUNK_POOL_ALLOCATOR_MACROS_SVH
`define CHUNK_POOL_ALLOCATOR_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another at the next clock edge.
`define CPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunk pool allocator package
// Widths, codes and item types used by the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cpa_pkg;

  localparam int MAX_CHUNKS = 1024;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int NODE_W     = 2 * CNT_W;
  localparam int PADDR_W    = 3;

  // Register index taken from the word address of the configuration port.
  localparam logic REG_POOL_CHUNKS = 1'b0;

  localparam logic [CNT_W-1:0] LINK_NONE = CNT_W'(MAX_CHUNKS);

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    FSM_IDLE = 1'b0,
    FSM_LOAD = 1'b1
  } fsm_t;

  typedef struct packed {
    op_t              opcode;
    logic [IDX_W-1:0] chunk_index;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] granted_index;
    logic [CNT_W-1:0] free_count;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/cpa_ram.sv =====
// ----------------------------------------------------------------------------
// Chunk pool allocator RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/chunk_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// Chunk pool allocator
// Free-list manager for a pool of equal-size chunks, with the head node held
// in registers and the remaining free-list nodes in a node memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and its result appears
// on out_item for exactly one cycle, marked by out_strobe, in the cycle after the
// item is taken; the receiver cannot stall it. A free, a refused request and an
// allocate that stays inside the head run leave busy low, so the next item can
// follow at once. An allocate that uses up the head run and follows its link
// raises busy while the linked node is read from the node memory through its
// registered read port. The node memory needs no clearing after reset; writing
// pool_chunks refills the pool at once.
`default_nettype none

module chunk_pool_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire cpa_pkg::in_item_t               in_item,
  output logic                                 out_strobe,
  output cpa_pkg::out_item_t                   out_item,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [cpa_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);

  import cpa_pkg::*;

  `include "chunk_pool_allocator_macros.svh"

  fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0] pool_chunks_r, pool_chunks_nxt;
  logic [IDX_W-1:0] head_index_r, head_index_nxt;
  logic [CNT_W-1:0] head_run_r, head_run_nxt;
  logic [CNT_W-1:0] head_link_r, head_link_nxt;
  logic [CNT_W-1:0] free_total_r, free_total_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             accept;
  logic             cfg_wr;
  logic [CNT_W-1:0] cfg_val;
  logic [CNT_W-1:0] run_dec;
  logic             load_start;
  logic             mem_we;
  logic [NODE_W-1:0] mem_rdata;

  assign pready = 1'b1;
  assign prdata = 32'(pool_chunks_r);
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_CHUNKS);

  always_comb begin
    cfg_val = pwdata[CNT_W-1:0];
    if (cfg_val == '0) begin
      cfg_val = CNT_W'(1);
    end else if (cfg_val > CNT_W'(MAX_CHUNKS)) begin
      cfg_val = CNT_W'(MAX_CHUNKS);
    end
  end

  // Outputs of the controller.
  always_comb begin
    case (state_r)
      FSM_IDLE: busy = 1'b0;
      FSM_LOAD: busy = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  assign accept  = start && !busy;
  assign run_dec = head_run_r - CNT_W'(1);

  // An allocate that empties the head run with a live link fetches that node.
  assign load_start = accept && (in_item.opcode == OP_ALLOC) &&
                      (free_total_r != '0) && (head_run_r != '0) &&
                      (run_dec == '0) && (head_link_r < LINK_NONE);

  assign mem_we = accept && (in_item.opcode == OP_FREE) &&
                  ({1'b0, in_item.chunk_index} < pool_chunks_r) && (head_run_r != '0);

  // Next state of the controller.
  always_comb begin
    case (state_r)
      FSM_IDLE: state_nxt = load_start ? FSM_LOAD : FSM_IDLE;
      FSM_LOAD: state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    pool_chunks_nxt = pool_chunks_r;
    head_index_nxt  = head_index_r;
    head_run_nxt    = head_run_r;
    head_link_nxt   = head_link_r;
    free_total_nxt  = free_total_r;
    out_strobe_nxt  = accept;
    out_item_nxt    = out_item_r;

    if (state_r == FSM_LOAD) begin
      head_run_nxt  = mem_rdata[NODE_W-1:CNT_W];
      head_link_nxt = mem_rdata[CNT_W-1:0];
    end

    if (accept) begin
      out_item_nxt.status        = ST_OK;
      out_item_nxt.granted_index = '0;
      if (in_item.opcode == OP_ALLOC) begin
        if ((free_total_r == '0) || (head_run_r == '0)) begin
          out_item_nxt.status = ST_EMPTY;
        end else begin
          out_item_nxt.granted_index = head_index_r;
          free_total_nxt = free_total_r - CNT_W'(1);
          head_run_nxt   = run_dec;
          if (run_dec != '0) begin
            if (head_index_r == IDX_W'(MAX_CHUNKS - 1)) begin
              head_run_nxt  = '0;
              head_link_nxt = LINK_NONE;
            end else begin
              head_index_nxt = head_index_r + IDX_W'(1);
            end
          end else if (head_link_r < LINK_NONE) begin
            // Run and link arrive from the node memory in the next cycle.
            head_index_nxt = head_link_r[IDX_W-1:0];
          end else begin
            head_link_nxt = LINK_NONE;
          end
        end
      end else begin
        if ({1'b0, in_item.chunk_index} >= pool_chunks_r) begin
          out_item_nxt.status = ST_RANGE;
        end else begin
          head_link_nxt  = (head_run_r != '0) ? {1'b0, head_index_r} : LINK_NONE;
          head_index_nxt = in_item.chunk_index;
          head_run_nxt   = CNT_W'(1);
          if (free_total_r < CNT_W'(MAX_CHUNKS)) begin
            free_total_nxt = free_total_r + CNT_W'(1);
          end
        end
      end
      out_item_nxt.free_count = free_total_nxt;
    end

    if (cfg_wr) begin
      pool_chunks_nxt = cfg_val;
      head_index_nxt  = '0;
      head_run_nxt    = cfg_val;
      head_link_nxt   = LINK_NONE;
      free_total_nxt  = cfg_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= FSM_IDLE;
      pool_chunks_r <= CNT_W'(MAX_CHUNKS);
      head_index_r  <= '0;
      head_run_r    <= CNT_W'(MAX_CHUNKS);
      head_link_r   <= LINK_NONE;
      free_total_r  <= CNT_W'(MAX_CHUNKS);
      out_strobe_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pool_chunks_r <= pool_chunks_nxt;
      head_index_r  <= head_index_nxt;
      head_run_r    <= head_run_nxt;
      head_link_r   <= head_link_nxt;
      free_total_r  <= free_total_nxt;
      out_strobe_r  <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // The old head node is saved at its own index when a chunk is pushed.
  cpa_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_CHUNKS)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (head_index_r),
    .wdata ({head_run_r, head_link_r}),
    .re    (load_start),
    .raddr (head_link_r[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  `CPA_ASSERT_NEXT(a_result_follows_item, accept, out_strobe,
                   "taken item produced no result")
  `CPA_ASSERT(a_no_spurious_result, out_strobe |-> $past(accept),
              "result without a taken item")
  `CPA_ASSERT_NEXT(a_load_one_cycle, state_r == FSM_LOAD, state_r == FSM_IDLE,
                   "node load lasted more than one cycle")
  `CPA_ASSERT(a_count_bounded, free_total_r <= CNT_W'(MAX_CHUNKS),
              "free count above pool capacity")

endmodule

`default_nettype wire
